[design/dlle_pkg.sv]
// Shared operation, status and sequencer state codes for the linked list engine.
package dlle_pkg;

	typedef enum logic [2:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_TAIL = 3'd1,
		OP_SEARCH   = 3'd2,
		OP_REMOVE   = 3'd3,
		OP_WALK_FWD = 3'd4,
		OP_WALK_BWD = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_NEW,
		S_INS_LINK,
		S_SRCH,
		S_REM_BACK,
		S_REM_BACK_WR,
		S_REM_FRONT,
		S_REM_FRONT_WR,
		S_REM_FREE,
		S_WALK,
		S_EMIT
	} state_t;

endpackage

[design/dlle_node_mem.sv]
// Node storage: one write port, one read port, registered read data.
module dlle_node_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 42
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// hold read data until the next read
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/dlle_free_pool.sv]
// Free node pool: a high-water mark for fresh nodes plus a stack of released ones.
module dlle_free_pool #(
	parameter int CAPACITY = 16,
	parameter int NW       = 4,
	parameter int IW       = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          alloc,
	input  logic          free,
	input  logic [NW-1:0] free_idx,
	output logic [NW-1:0] alloc_idx
);

	logic [NW-1:0] stack [CAPACITY];
	logic [IW-1:0] sp_q;
	logic [IW-1:0] hwm_q;
	logic [IW-1:0] sp_dec;
	logic [NW-1:0] stk_rd_q;
	logic          from_stack_s1;
	logic [NW-1:0] hwm_s1;

	assign sp_dec = sp_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			hwm_q <= '0;
		end else if (alloc) begin
			if (sp_q != '0) begin
				sp_q <= sp_dec;
			end else begin
				hwm_q <= hwm_q + 1'b1;
			end
		end else if (free) begin
			sp_q <= sp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc) begin
			from_stack_s1 <= (sp_q != '0);
			hwm_s1        <= hwm_q[NW-1:0];
			stk_rd_q      <= stack[sp_dec[NW-1:0]];
		end
		if (free) begin
			stack[sp_q[NW-1:0]] <= free_idx;
		end
	end

	// valid in the cycle after alloc
	assign alloc_idx = from_stack_s1 ? stk_rd_q : hwm_s1;

endmodule

[design/doubly_linked_list_engine_core.sv]
// Top level of the doubly linked list engine: sequencer, list registers and result register.
// Insert allocates and links a node; search and remove read node by node from the head; a
// walk emits one result per cycle while the output is not stalled; one item at a time.
// Throughput is set by the single read port of the node memory, one node per cycle unless the output stalls.
// Reset empties the list at once; no clearing pass, free nodes come from a high-water mark.
module doubly_linked_list_engine_core import dlle_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         op,
	input  logic signed [31:0]                 value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic signed [31:0]                 item_value,
	output logic [$clog2(CAPACITY + 1)-1:0]    count,
	output logic                               last
);

	localparam int IW = $clog2(CAPACITY + 1);
	localparam int NW = $clog2(CAPACITY);
	localparam int DW = 32 + 2 * IW;
	localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);

	// node word layout: {value, next, prev}
	state_t        state_q, state_d;
	logic [IW-1:0] head_q, head_d;
	logic [IW-1:0] tail_q, tail_d;
	logic [IW-1:0] cnt_q, cnt_d;
	logic [2:0]    op_q, op_d;
	logic [31:0]   val_q, val_d;
	logic [IW-1:0] cur_q, cur_d;
	logic [IW-1:0] link_q, link_d;
	logic [IW-1:0] front_q, front_d;
	logic [IW-1:0] seen_q, seen_d;
	status_t       pst_q, pst_d;
	logic [31:0]   pval_q, pval_d;

	logic          out_valid_q, out_valid_d;
	status_t       status_q, status_d;
	logic [31:0]   item_q, item_d;
	logic [IW-1:0] count_q, count_d;
	logic          last_q, last_d;

	logic          rd_en, wr_en;
	logic [NW-1:0] rd_addr, wr_addr;
	logic [DW-1:0] rd_data, wr_data;
	logic [31:0]   rd_value;
	logic [IW-1:0] rd_next, rd_prev;

	logic          alloc, free;
	logic [NW-1:0] free_idx, alloc_idx;
	logic [IW-1:0] new_idx;

	logic          out_free;
	logic [IW-1:0] seen_inc;
	logic [IW-1:0] walk_start;
	logic [IW-1:0] walk_nxt;
	logic          walk_more;

	dlle_node_mem #(
		.DEPTH (CAPACITY),
		.AW    (NW),
		.DW    (DW)
	) u_node_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	dlle_free_pool #(
		.CAPACITY (CAPACITY),
		.NW       (NW),
		.IW       (IW)
	) u_free_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.alloc     (alloc),
		.free      (free),
		.free_idx  (free_idx),
		.alloc_idx (alloc_idx)
	);

	assign rd_value = rd_data[DW-1 -: 32];
	assign rd_next  = rd_data[2*IW-1 -: IW];
	assign rd_prev  = rd_data[IW-1:0];
	assign new_idx  = IW'(alloc_idx);

	// The result register frees up when empty or when its item is taken this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign seen_inc = seen_q + 1'b1;

	// one item in flight: take a new one only while the sequencer rests
	assign in_stall = (state_q != S_IDLE);

	assign walk_start = (op == OP_WALK_FWD) ? head_q : tail_q;
	assign walk_nxt   = (op_q == OP_WALK_FWD) ? rd_next : rd_prev;
	assign walk_more  = (walk_nxt < NULL_IDX) && (seen_inc < cnt_q);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		cnt_d       = cnt_q;
		op_d        = op_q;
		val_d       = val_q;
		cur_d       = cur_q;
		link_d      = link_q;
		front_d     = front_q;
		seen_d      = seen_q;
		pst_d       = pst_q;
		pval_d      = pval_q;
		out_valid_d = out_valid_q && out_stall;
		status_d    = status_q;
		item_d      = item_q;
		count_d     = count_q;
		last_d      = last_q;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = '0;
		alloc       = 1'b0;
		free        = 1'b0;
		free_idx    = cur_q[NW-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d   = op;
					val_d  = value;
					seen_d = '0;
					pval_d = '0;
					unique case (op)
						OP_INS_HEAD, OP_INS_TAIL: begin
							// drop the insert when every node is taken
							if (cnt_q >= NULL_IDX) begin
								pst_d   = ST_FULL;
								state_d = S_EMIT;
							end else begin
								alloc   = 1'b1;
								state_d = S_INS_NEW;
							end
						end
						OP_SEARCH, OP_REMOVE: begin
							if (cnt_q == '0 || head_q >= NULL_IDX) begin
								pst_d   = ST_NOTFOUND;
								state_d = S_EMIT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q[NW-1:0];
								cur_d   = head_q;
								state_d = S_SRCH;
							end
						end
						OP_WALK_FWD, OP_WALK_BWD: begin
							if (cnt_q == '0 || walk_start >= NULL_IDX) begin
								pst_d   = ST_EMPTY;
								state_d = S_EMIT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = walk_start[NW-1:0];
								state_d = S_WALK;
							end
						end
						default: begin
							// unused codes: no result, no state change
						end
					endcase
				end
			end

			S_INS_NEW: begin
				cur_d   = new_idx;
				wr_en   = 1'b1;
				wr_addr = alloc_idx;
				if (cnt_q == '0 || head_q >= NULL_IDX || tail_q >= NULL_IDX) begin
					wr_data = {val_q, NULL_IDX, NULL_IDX};
					head_d  = new_idx;
					tail_d  = new_idx;
					cnt_d   = cnt_q + 1'b1;
					pst_d   = ST_OK;
					state_d = S_EMIT;
				end else if (op_q == OP_INS_HEAD) begin
					// link in front of the old head, then patch its prev link
					wr_data = {val_q, head_q, NULL_IDX};
					rd_en   = 1'b1;
					rd_addr = head_q[NW-1:0];
					link_d  = head_q;
					head_d  = new_idx;
					state_d = S_INS_LINK;
				end else begin
					wr_data = {val_q, NULL_IDX, tail_q};
					rd_en   = 1'b1;
					rd_addr = tail_q[NW-1:0];
					link_d  = tail_q;
					tail_d  = new_idx;
					state_d = S_INS_LINK;
				end
			end

			S_INS_LINK: begin
				wr_en   = 1'b1;
				wr_addr = link_q[NW-1:0];
				if (op_q == OP_INS_HEAD) begin
					wr_data = {rd_value, rd_next, cur_q};
				end else begin
					wr_data = {rd_value, cur_q, rd_prev};
				end
				cnt_d   = cnt_q + 1'b1;
				pst_d   = ST_OK;
				state_d = S_EMIT;
			end

			S_SRCH: begin
				// compare one node per cycle while reading the next
				if (rd_value == val_q) begin
					if (op_q == OP_SEARCH) begin
						pst_d   = ST_OK;
						pval_d  = rd_value;
						state_d = S_EMIT;
					end else begin
						link_d  = rd_prev;
						front_d = rd_next;
						state_d = S_REM_BACK;
					end
				end else if (rd_next < NULL_IDX && seen_inc < cnt_q) begin
					rd_en   = 1'b1;
					rd_addr = rd_next[NW-1:0];
					cur_d   = rd_next;
					seen_d  = seen_inc;
				end else begin
					pst_d   = ST_NOTFOUND;
					state_d = S_EMIT;
				end
			end

			S_REM_BACK: begin
				if (link_q >= NULL_IDX) begin
					head_d  = front_q;
					state_d = S_REM_FRONT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = link_q[NW-1:0];
					state_d = S_REM_BACK_WR;
				end
			end

			S_REM_BACK_WR: begin
				wr_en   = 1'b1;
				wr_addr = link_q[NW-1:0];
				wr_data = {rd_value, front_q, rd_prev};
				state_d = S_REM_FRONT;
			end

			S_REM_FRONT: begin
				if (front_q >= NULL_IDX) begin
					tail_d  = link_q;
					state_d = S_REM_FREE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = front_q[NW-1:0];
					state_d = S_REM_FRONT_WR;
				end
			end

			S_REM_FRONT_WR: begin
				wr_en   = 1'b1;
				wr_addr = front_q[NW-1:0];
				wr_data = {rd_value, rd_next, link_q};
				state_d = S_REM_FREE;
			end

			S_REM_FREE: begin
				// release the node; an emptied list loses head and tail
				free  = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == IW'(1)) begin
					head_d = NULL_IDX;
					tail_d = NULL_IDX;
				end
				pst_d   = ST_OK;
				state_d = S_EMIT;
			end

			S_WALK: begin
				// emit one node per cycle; hold the read data while stalled
				if (out_free) begin
					out_valid_d = 1'b1;
					status_d    = ST_OK;
					item_d      = rd_value;
					count_d     = cnt_q;
					last_d      = !walk_more;
					if (walk_more) begin
						rd_en   = 1'b1;
						rd_addr = walk_nxt[NW-1:0];
						seen_d  = seen_inc;
					end else begin
						state_d = S_IDLE;
					end
				end
			end

			S_EMIT: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					status_d    = pst_q;
					item_d      = pval_q;
					count_d     = cnt_q;
					last_d      = 1'b1;
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NULL_IDX;
			tail_q      <= NULL_IDX;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		val_q    <= val_d;
		cur_q    <= cur_d;
		link_q   <= link_d;
		front_q  <= front_d;
		seen_q   <= seen_d;
		pst_q    <= pst_d;
		pval_q   <= pval_d;
		status_q <= status_d;
		item_q   <= item_d;
		count_q  <= count_d;
		last_q   <= last_d;
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign item_value = item_q;
	assign count      = count_q;
	assign last       = last_q;

endmodule
